/* src/ycts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the YUV colour table segmenter.
// Used by ycts_bounds, ycts_engine and yuv_color_table_segmenter_unit.
package ycts_pkg;

  localparam int INDEX_BITS_DEF = 6;
  localparam int CLASS_BITS_DEF = 4;
  localparam int SAMPLE_W       = 8;
  localparam int CLASS_W        = 4;
  localparam int RUN_W          = 19;
  localparam int RADIUS_W       = 5;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd4;

  typedef enum logic [2:0] {
    FUNC_CLASSIFY = 3'd0,
    FUNC_PAINT    = 3'd1,
    FUNC_CLEAR    = 3'd2,
    FUNC_LOAD     = 3'd3,
    FUNC_DUMP     = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PAINT,
    ST_CLEAR,
    ST_LOAD,
    ST_DUMP_HEAD,
    ST_DUMP_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]          func;
    logic [SAMPLE_W-1:0] luma_first;
    logic [SAMPLE_W-1:0] chroma_u;
    logic [SAMPLE_W-1:0] luma_second;
    logic [SAMPLE_W-1:0] chroma_v;
    logic [CLASS_W-1:0]  class_in;
    logic [RUN_W-1:0]    run_length_in;
  } in_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_first;
    logic [CLASS_W-1:0] class_second;
    logic [RUN_W-1:0]   run_length_out;
    logic [CLASS_W-1:0] run_class;
    logic               status;
    logic               table_end;
  } out_t;

endpackage

/* src/ycts_bounds.sv */
`timescale 1ns / 1ps
// Per-axis bounds of the painted cube: [max(s-r,0), min(s+r,axis length)).
// Depends on ycts_pkg.
module ycts_bounds #(
  parameter int INDEX_BITS = ycts_pkg::INDEX_BITS_DEF
) (
  input  logic [INDEX_BITS-1:0]         sample_idx,
  input  logic [ycts_pkg::RADIUS_W-1:0] radius,
  output logic [INDEX_BITS-1:0]         lo,
  output logic [INDEX_BITS:0]           hi
);
  import ycts_pkg::*;

  localparam int BW       = ((INDEX_BITS > RADIUS_W) ? INDEX_BITS : RADIUS_W) + 1;
  localparam int AXIS_W   = INDEX_BITS + 1;
  localparam int AXIS_LEN = 1 << INDEX_BITS;

  logic [BW-1:0] s_ext;
  logic [BW-1:0] r_ext;
  logic [BW-1:0] sum;
  logic [BW-1:0] diff;

  assign s_ext = BW'(sample_idx);
  assign r_ext = BW'(radius);
  assign sum   = s_ext + r_ext;
  assign diff  = s_ext - r_ext;

  // lower bound saturates at zero rather than wrapping
  assign lo = (s_ext > r_ext) ? INDEX_BITS'(diff) : '0;
  assign hi = (sum > BW'(AXIS_LEN)) ? AXIS_W'(AXIS_LEN) : AXIS_W'(sum);

endmodule

/* src/ycts_engine.sv */
`timescale 1ns / 1ps
// Class table memory and the sequencer that reads, sweeps and scans it.
// Depends on ycts_pkg and ycts_bounds.
module ycts_engine #(
  parameter int INDEX_BITS = ycts_pkg::INDEX_BITS_DEF,
  parameter int CLASS_BITS = ycts_pkg::CLASS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ycts_pkg::RADIUS_W-1:0] radius,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ycts_pkg::in_t                 item,
  output logic                          res_valid,
  input  logic                          res_take,
  output ycts_pkg::out_t                res_word
);
  import ycts_pkg::*;

  localparam int TABLE_BITS = 3 * INDEX_BITS;
  localparam int TABLE_LEN  = 1 << TABLE_BITS;
  localparam int AXIS_W     = INDEX_BITS + 1;
  localparam int SUM_W      = ((TABLE_BITS > RUN_W) ? TABLE_BITS : RUN_W) + 1;

  // table storage, one read-data register per port
  logic [CLASS_BITS-1:0] mem [0:TABLE_LEN-1];
  logic [CLASS_BITS-1:0] rdata_a;
  logic [CLASS_BITS-1:0] rdata_b;

  logic                  mem_we;
  logic [TABLE_BITS-1:0] mem_waddr;
  logic [CLASS_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [TABLE_BITS-1:0] raddr_a;
  logic [TABLE_BITS-1:0] raddr_b;

  state_t state;
  state_t state_next;

  // control
  logic                  rd_cls;
  logic [TABLE_BITS-1:0] load_pos;
  logic [TABLE_BITS-1:0] dump_pos;
  logic [TABLE_BITS-1:0] wr_addr;

  // payload
  logic [RUN_W-1:0]      cnt;
  logic [CLASS_BITS-1:0] cls;
  logic [INDEX_BITS-1:0] pa;
  logic [INDEX_BITS-1:0] pb;
  logic [INDEX_BITS-1:0] pc;
  logic [INDEX_BITS-1:0] ulo;
  logic [INDEX_BITS-1:0] vlo;
  logic [AXIS_W-1:0]     yhi;
  logic [AXIS_W-1:0]     uhi;
  logic [AXIS_W-1:0]     vhi;
  logic [TABLE_BITS-1:0] scan;
  logic [CLASS_BITS-1:0] run_cls;
  out_t                  res;

  logic                  accept;
  logic [INDEX_BITS-1:0] luma1_idx;
  logic [INDEX_BITS-1:0] luma2_idx;
  logic [INDEX_BITS-1:0] u_idx;
  logic [INDEX_BITS-1:0] v_idx;
  logic [INDEX_BITS-1:0] ylo_in;
  logic [INDEX_BITS-1:0] ulo_in;
  logic [INDEX_BITS-1:0] vlo_in;
  logic [AXIS_W-1:0]     yhi_in;
  logic [AXIS_W-1:0]     uhi_in;
  logic [AXIS_W-1:0]     vhi_in;
  logic [SUM_W-1:0]      load_sum;
  logic                  load_ovf;
  logic                  load_empty;
  logic                  paint_a_last;
  logic                  paint_b_last;
  logic                  paint_c_last;
  logic                  paint_last;
  logic                  dump_match;
  logic                  dump_finish;
  logic [CLASS_BITS-1:0] dump_cls;
  logic [TABLE_BITS:0]   dump_end;
  logic [TABLE_BITS:0]   dump_len;
  out_t                  acc_res;
  out_t                  cls_res;

  assign luma1_idx = item.luma_first[SAMPLE_W-1 -: INDEX_BITS];
  assign luma2_idx = item.luma_second[SAMPLE_W-1 -: INDEX_BITS];
  assign u_idx     = item.chroma_u[SAMPLE_W-1 -: INDEX_BITS];
  assign v_idx     = item.chroma_v[SAMPLE_W-1 -: INDEX_BITS];

  ycts_bounds #(.INDEX_BITS(INDEX_BITS)) u_bounds_y (
    .sample_idx(luma1_idx), .radius(radius), .lo(ylo_in), .hi(yhi_in)
  );
  ycts_bounds #(.INDEX_BITS(INDEX_BITS)) u_bounds_u (
    .sample_idx(u_idx), .radius(radius), .lo(ulo_in), .hi(uhi_in)
  );
  ycts_bounds #(.INDEX_BITS(INDEX_BITS)) u_bounds_v (
    .sample_idx(v_idx), .radius(radius), .lo(vlo_in), .hi(vhi_in)
  );

  assign load_sum   = SUM_W'(load_pos) + SUM_W'(item.run_length_in);
  assign load_ovf   = load_sum > SUM_W'(TABLE_LEN);
  assign load_empty = (item.run_length_in == '0);

  assign paint_c_last = (AXIS_W'(pc) + AXIS_W'(1)) == vhi;
  assign paint_b_last = (AXIS_W'(pb) + AXIS_W'(1)) == uhi;
  assign paint_a_last = (AXIS_W'(pa) + AXIS_W'(1)) == yhi;
  assign paint_last   = paint_a_last && paint_b_last && paint_c_last;

  // the head word opens the run, so it always matches
  assign dump_match  = (state == ST_DUMP_HEAD) || (rdata_a == run_cls);
  assign dump_finish = !dump_match || (&scan);
  assign dump_cls    = (state == ST_DUMP_HEAD) ? rdata_a : run_cls;
  assign dump_end    = dump_match ? (TABLE_BITS + 1)'(TABLE_LEN) : {1'b0, scan};
  assign dump_len    = dump_end - {1'b0, dump_pos};

  // a classify word waits in the read-data registers until taken
  assign res_valid  = rd_cls || (state == ST_DONE);
  assign item_stall = !((state == ST_IDLE) && (!rd_cls || res_take));
  assign accept     = item_valid && !item_stall;

  always_comb begin
    cls_res              = '0;
    cls_res.class_first  = CLASS_W'(rdata_a);
    cls_res.class_second = CLASS_W'(rdata_b);
    res_word             = rd_cls ? cls_res : res;
  end

  always_comb begin
    acc_res = '0;
    if (item.func == FUNC_LOAD) begin
      acc_res.status = load_ovf;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = wr_addr;
    mem_wdata  = cls;
    mem_re     = 1'b0;
    raddr_a    = {luma1_idx, u_idx, v_idx};
    raddr_b    = {luma2_idx, u_idx, v_idx};
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (&wr_addr) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (item.func)
            FUNC_CLASSIFY: begin
              mem_re = 1'b1;
            end
            FUNC_PAINT: begin
              state_next = (radius == '0) ? ST_DONE : ST_PAINT;
            end
            FUNC_CLEAR: begin
              state_next = ST_CLEAR;
            end
            FUNC_LOAD: begin
              state_next = (load_ovf || load_empty) ? ST_DONE : ST_LOAD;
            end
            FUNC_DUMP: begin
              mem_re     = 1'b1;
              raddr_a    = dump_pos;
              state_next = ST_DUMP_HEAD;
            end
            default: begin
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_PAINT: begin
        mem_we    = 1'b1;
        mem_waddr = {pa, pb, pc};
        if (paint_last) begin
          state_next = ST_DONE;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (&wr_addr) begin
          state_next = ST_DONE;
        end
      end
      ST_LOAD: begin
        mem_we = 1'b1;
        if (cnt == RUN_W'(1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DUMP_HEAD, ST_DUMP_SCAN: begin
        if (dump_finish) begin
          state_next = ST_DONE;
        end else begin
          // read one word ahead while comparing the current one
          mem_re     = 1'b1;
          raddr_a    = scan + TABLE_BITS'(1);
          state_next = ST_DUMP_SCAN;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cls   <= 1'b0;
      load_pos <= '0;
      dump_pos <= '0;
      wr_addr  <= '0;
    end else begin
      if (accept && (item.func == FUNC_CLASSIFY)) begin
        rd_cls <= 1'b1;
      end else if (res_take) begin
        rd_cls <= 1'b0;
      end
      unique case (state)
        ST_INIT, ST_CLEAR: begin
          wr_addr <= wr_addr + TABLE_BITS'(1);
        end
        ST_IDLE: begin
          if (accept && (item.func == FUNC_CLEAR)) begin
            wr_addr <= '0;
          end else if (accept && (item.func == FUNC_LOAD)) begin
            wr_addr <= load_pos;
          end
        end
        ST_LOAD: begin
          wr_addr <= wr_addr + TABLE_BITS'(1);
          if (cnt == RUN_W'(1)) begin
            // wraps to zero when the run ends on the last entry
            load_pos <= wr_addr + TABLE_BITS'(1);
          end
        end
        ST_DUMP_HEAD, ST_DUMP_SCAN: begin
          if (dump_finish) begin
            dump_pos <= dump_match ? '0 : scan;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cls  <= CLASS_BITS'(item.class_in);
          cnt  <= item.run_length_in;
          pa   <= ylo_in;
          pb   <= ulo_in;
          pc   <= vlo_in;
          ulo  <= ulo_in;
          vlo  <= vlo_in;
          yhi  <= yhi_in;
          uhi  <= uhi_in;
          vhi  <= vhi_in;
          scan <= dump_pos;
          res  <= acc_res;
        end
      end
      ST_PAINT: begin
        if (!paint_c_last) begin
          pc <= pc + INDEX_BITS'(1);
        end else begin
          pc <= vlo;
          if (!paint_b_last) begin
            pb <= pb + INDEX_BITS'(1);
          end else begin
            pb <= ulo;
            pa <= pa + INDEX_BITS'(1);
          end
        end
      end
      ST_LOAD: begin
        cnt <= cnt - RUN_W'(1);
        if (cnt == RUN_W'(1)) begin
          res.table_end <= &wr_addr;
        end
      end
      ST_DUMP_HEAD, ST_DUMP_SCAN: begin
        if (state == ST_DUMP_HEAD) begin
          run_cls <= rdata_a;
        end
        if (dump_finish) begin
          res.run_length_out <= RUN_W'(dump_len);
          res.run_class      <= CLASS_W'(dump_cls);
          res.table_end      <= dump_match;
        end else begin
          scan <= scan + TABLE_BITS'(1);
        end
      end
      default: begin
      end
    endcase
  end

  a_cls_only_idle: assert property (@(posedge clk) disable iff (rst)
    rd_cls |-> (state == ST_IDLE))
    else $error("classify word pending outside idle");

  a_cls_lands: assert property (@(posedge clk) disable iff (rst)
    (accept && (item.func == FUNC_CLASSIFY)) |=> rd_cls)
    else $error("classify read not flagged after accept");

  a_dump_ptr: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(dump_pos)) |->
      ($past(state) == ST_DUMP_HEAD || $past(state) == ST_DUMP_SCAN))
    else $error("dump pointer moved outside a dump scan");

  a_load_ptr: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(load_pos)) |-> ($past(state) == ST_LOAD))
    else $error("load pointer moved outside a load run");

endmodule

/* src/yuv_color_table_segmenter_unit.sv */
`timescale 1ns / 1ps
// YUV colour class table segmenter: top level with the paint radius
// register and the result register. Depends on ycts_pkg and ycts_engine.
//
// Items come in on item/item_valid/item_stall; a word is taken on a clock
// edge with item_valid high and item_stall low. Each item gives exactly one
// word on result/result_valid/result_stall. cfg_write loads cfg_data into
// the paint radius (reset value 4); write it only while the block is idle.
//
// Classify reads both pixels through the two table read ports in the same
// cycle and streams at one item per cycle while result_stall is low; its word
// passes the read-data registers, then the result register. Other operations
// hold item_stall while the sequencer walks the table, one entry per cycle:
//   paint  - writes each cube entry (up to (2r)^3) through the single write port
//   clear  - writes all 2^(3*INDEX_BITS) entries (262144 by default)
//   load   - writes run length entries; an overflow or empty run writes none
//   dump   - reads each entry in the run and, unless the run ends on the
//            last entry, the entry after it
// After reset the table is swept to the nothing class with item_stall high;
// cfg writes are still taken then.
// When result_stall is high the result word holds; the block still takes
// one further item and keeps its word until the result register frees.
module yuv_color_table_segmenter_unit #(
  parameter int INDEX_BITS = ycts_pkg::INDEX_BITS_DEF,
  parameter int CLASS_BITS = ycts_pkg::CLASS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  ycts_pkg::in_t                 item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output ycts_pkg::out_t                result,
  input  logic                          cfg_write,
  input  logic [ycts_pkg::RADIUS_W-1:0] cfg_data
);
  import ycts_pkg::*;

  logic [RADIUS_W-1:0] paint_radius;
  logic                res_valid;
  logic                res_take;
  out_t                res_word;

  assign res_take = !result_valid || !result_stall;

  ycts_engine #(
    .INDEX_BITS(INDEX_BITS),
    .CLASS_BITS(CLASS_BITS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .radius    (paint_radius),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res_word  (res_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      paint_radius <= RADIUS_RESET;
    end else if (cfg_write) begin
      paint_radius <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      result <= res_word;
    end
  end

endmodule
